// File: src/lock_manager_deadlock_detect_core_assert.svh
// Assertion helpers for the lock manager core.
// Both sample on clk and are disabled while rst_n is low.
`ifndef LOCK_MANAGER_DEADLOCK_DETECT_CORE_ASSERT_SVH
`define LOCK_MANAGER_DEADLOCK_DETECT_CORE_ASSERT_SVH

// Same-cycle implication
`define LMDD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define LMDD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/lmdd_pkg.sv
package lmdd_pkg;

    localparam int NUM_PROCS = 16;
    localparam int NUM_LOCKS = 16;
    localparam int PID_W     = 4;
    localparam int LOCK_W    = 4;
    localparam int MAX_RES   = 16;

    // "none" markers, one above the largest valid number
    localparam logic [PID_W:0]  NO_PID  = (PID_W + 1)'(NUM_PROCS);
    localparam logic [LOCK_W:0] NO_LOCK = (LOCK_W + 1)'(NUM_LOCKS);

    // Operation codes
    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_TRY    = 2'd1;
    localparam logic [1:0] OP_LOCK   = 2'd2;
    localparam logic [1:0] OP_UNLOCK = 2'd3;

    // Status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_QUEUED  = 3'd1;
    localparam logic [2:0] ST_REFUSED = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_NOLOCK  = 3'd4;

    typedef struct packed {
        logic [1:0]        op;
        logic [PID_W-1:0]  requester;
        logic [LOCK_W-1:0] lock_id;
    } cmd_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [LOCK_W-1:0] given_lock;
        logic              deadlock;
        logic [PID_W-1:0]  member_pid;
        logic [PID_W:0]    woken_pid;
        logic              last;
    } rsp_t;

    // Lock table entry
    typedef struct packed {
        logic              busy;
        logic [PID_W:0]    holder;
        logic [PID_W:0]    qhead;
        logic [PID_W:0]    qtail;
    } lk_ent_t;

    // Process table entry
    typedef struct packed {
        logic [LOCK_W:0]   waits_on;
        logic [PID_W:0]    next_waiter;
    } pr_ent_t;

endpackage

// File: src/lock_manager_deadlock_detect_core.sv
// Lock table with FIFO wait queues and wait-for deadlock detection. A command
// word is taken when start is high and busy is low; each result word is shown
// on result for exactly one cycle with done high, and the receiver cannot
// stall it. The last word of a command appears in the cycle busy drops, so a
// new command may be issued at once. Allocate, try-lock, unlock and all
// refusals give one word; unlock that wakes a waiter first reads the head
// waiter's process entry. A blocking lock walks the wait-for chain, adding at
// most 16 processes; each step reads the process table, then the lock table,
// both simple dual-port RAMs with registered read data. It then updates the
// lock, links the old queue tail when it joins a non-empty queue, and lists
// the deadlocked processes one per word. Commands run one at a time, so
// table accesses never overlap.
`include "lock_manager_deadlock_detect_core_assert.svh"

module lock_manager_deadlock_detect_core
    import lmdd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  cmd_t command,
    output logic busy,
    output logic done,
    output rsp_t result
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK,
        S_WALK_L,
        S_WALK_P,
        S_DECIDE,
        S_QLINK,
        S_UNL,
        S_FIN,
        S_EMIT
    } state_t;

    state_t              state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    lk_ent_t             ent_reg, ent_next;
    logic [PID_W:0]      h_reg, h_next;
    logic [PID_W:0]      pursuer_reg, pursuer_next;
    logic [PID_W:0]      cnt_reg, cnt_next;
    logic [NUM_PROCS-1:0] mask_reg, mask_next;
    logic                found_reg, found_next;
    logic [2:0]          st_reg, st_next;
    logic [LOCK_W:0]     alloc_cnt_reg, alloc_cnt_next;
    logic [NUM_PROCS-1:0] pvalid_reg, pvalid_next;
    logic                done_reg, done_next;
    rsp_t                rsp_reg, rsp_next;

    // Table RAMs
    lk_ent_t             lock_mem [NUM_LOCKS];
    pr_ent_t             proc_mem [NUM_PROCS];
    lk_ent_t             lk_rd_reg;
    pr_ent_t             pr_rd_reg;

    logic                lk_re, lk_we;
    logic [LOCK_W-1:0]   lk_raddr, lk_waddr;
    lk_ent_t             lk_wdata;
    logic                pr_re, pr_we;
    logic [PID_W-1:0]    pr_raddr, pr_waddr;
    pr_ent_t             pr_wdata;

    // Scratch values
    logic [PID_W:0]      h_cur;
    logic [LOCK_W:0]     w_cur;
    logic [LOCK_W:0]     req_wait;
    logic [PID_W-1:0     ] low_pid;
    logic [NUM_PROCS-1:0] low_bit;
    logic [PID_W:0]      nx_head;
    logic [PID_W:0]      req_ext;
    rsp_t                one_rsp;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = rsp_reg;

    // Lowest pending member
    always_comb
    begin
        low_pid = '0;
        for (int i = NUM_PROCS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                low_pid = PID_W'(i);
            end
        end
        low_bit = NUM_PROCS'(1) << low_pid;
    end

    // Control and table access
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        ent_next       = ent_reg;
        h_next         = h_reg;
        pursuer_next   = pursuer_reg;
        cnt_next       = cnt_reg;
        mask_next      = mask_reg;
        found_next     = found_reg;
        st_next        = st_reg;
        alloc_cnt_next = alloc_cnt_reg;
        pvalid_next    = pvalid_reg;
        done_next      = 1'b0;
        rsp_next       = rsp_reg;

        lk_re    = 1'b0;
        lk_raddr = cmd_reg.lock_id;
        lk_we    = 1'b0;
        lk_waddr = cmd_reg.lock_id;
        lk_wdata = lk_rd_reg;
        pr_re    = 1'b0;
        pr_raddr = cmd_reg.requester;
        pr_we    = 1'b0;
        pr_waddr = cmd_reg.requester;
        pr_wdata = pr_rd_reg;

        req_ext  = {1'b0, cmd_reg.requester};
        h_cur    = lk_rd_reg.holder;
        req_wait = pvalid_reg[cmd_reg.requester] ? pr_rd_reg.waits_on : NO_LOCK;
        if (h_reg[PID_W-1:0] == cmd_reg.requester)
        begin
            w_cur = {1'b0, cmd_reg.lock_id};
        end
        else if (pvalid_reg[h_reg[PID_W-1:0]])
        begin
            w_cur = pr_rd_reg.waits_on;
        end
        else
        begin
            w_cur = NO_LOCK;
        end
        nx_head = (pr_rd_reg.next_waiter < NO_PID) ? pr_rd_reg.next_waiter : NO_PID;

        one_rsp            = '0;
        one_rsp.woken_pid  = NO_PID;
        one_rsp.last       = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = command;
                    lk_re    = 1'b1;
                    lk_raddr = command.lock_id;
                    pr_re    = 1'b1;
                    pr_raddr = command.requester;
                    state_next = S_CHK;
                end
            end

            S_CHK:
            begin
                ent_next = lk_rd_reg;
                if (cmd_reg.op == OP_ALLOC)
                begin
                    if (alloc_cnt_reg >= (LOCK_W + 1)'(NUM_LOCKS))
                    begin
                        one_rsp.status = ST_FULL;
                    end
                    else
                    begin
                        lk_we    = 1'b1;
                        lk_waddr = alloc_cnt_reg[LOCK_W-1:0];
                        lk_wdata = '{busy: 1'b0, holder: NO_PID, qhead: NO_PID,
                                     qtail: NO_PID};
                        one_rsp.status     = ST_OK;
                        one_rsp.given_lock = alloc_cnt_reg[LOCK_W-1:0];
                        alloc_cnt_next     = alloc_cnt_reg + 1'b1;
                    end
                    rsp_next   = one_rsp;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if ({1'b0, cmd_reg.lock_id} >= alloc_cnt_reg)
                begin
                    one_rsp.status = ST_NOLOCK;
                    rsp_next   = one_rsp;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (cmd_reg.op == OP_TRY)
                begin
                    if (lk_rd_reg.busy)
                    begin
                        one_rsp.status = ST_REFUSED;
                    end
                    else
                    begin
                        lk_we           = 1'b1;
                        lk_wdata.busy   = 1'b1;
                        lk_wdata.holder = req_ext;
                        one_rsp.status  = ST_OK;
                    end
                    rsp_next   = one_rsp;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (cmd_reg.op == OP_LOCK)
                begin
                    if (req_wait < NO_LOCK)
                    begin
                        one_rsp.status = ST_REFUSED;
                        rsp_next   = one_rsp;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // lock entry read data stays put for the first step
                        pursuer_next = NO_PID;
                        cnt_next     = '0;
                        mask_next    = '0;
                        state_next   = S_WALK_L;
                    end
                end
                else
                begin
                    // unlock
                    if (lk_rd_reg.holder != req_ext)
                    begin
                        one_rsp.status = ST_REFUSED;
                        rsp_next   = one_rsp;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (lk_rd_reg.qhead >= NO_PID)
                    begin
                        lk_we           = 1'b1;
                        lk_wdata.busy   = 1'b0;
                        lk_wdata.holder = NO_PID;
                        one_rsp.status  = ST_OK;
                        rsp_next   = one_rsp;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        pr_re      = 1'b1;
                        pr_raddr   = lk_rd_reg.qhead[PID_W-1:0];
                        state_next = S_UNL;
                    end
                end
            end

            // Holder known: check, then fetch what it waits on
            S_WALK_L:
            begin
                if (h_cur >= NO_PID || cnt_reg >= (PID_W + 1)'(NUM_PROCS))
                begin
                    found_next = 1'b0;
                    state_next = S_DECIDE;
                end
                else if (pursuer_reg == req_ext)
                begin
                    found_next = 1'b1;
                    state_next = S_DECIDE;
                end
                else
                begin
                    pr_re      = 1'b1;
                    pr_raddr   = h_cur[PID_W-1:0];
                    h_next     = h_cur;
                    state_next = S_WALK_P;
                end
            end

            // Awaited lock known: record member, fetch that lock's holder
            S_WALK_P:
            begin
                if (w_cur >= NO_LOCK)
                begin
                    found_next = 1'b0;
                    state_next = S_DECIDE;
                end
                else
                begin
                    pursuer_next = h_reg;
                    mask_next    = mask_reg | (NUM_PROCS'(1) << h_reg[PID_W-1:0]);
                    cnt_next     = cnt_reg + 1'b1;
                    lk_re        = 1'b1;
                    lk_raddr     = w_cur[LOCK_W-1:0];
                    state_next   = S_WALK_L;
                end
            end

            S_DECIDE:
            begin
                lk_we    = 1'b1;
                lk_wdata = ent_reg;
                if (!ent_reg.busy)
                begin
                    lk_wdata.busy   = 1'b1;
                    lk_wdata.holder = req_ext;
                    st_next         = ST_OK;
                    state_next      = S_FIN;
                end
                else
                begin
                    st_next  = ST_QUEUED;
                    pr_we    = 1'b1;
                    pr_waddr = cmd_reg.requester;
                    pr_wdata = '{waits_on: {1'b0, cmd_reg.lock_id}, next_waiter: NO_PID};
                    pvalid_next[cmd_reg.requester] = 1'b1;
                    lk_wdata.qtail = req_ext;
                    if (ent_reg.qtail < NO_PID)
                    begin
                        // old tail gets linked next cycle
                        pr_re      = 1'b1;
                        pr_raddr   = ent_reg.qtail[PID_W-1:0];
                        state_next = S_QLINK;
                    end
                    else
                    begin
                        lk_wdata.qhead = req_ext;
                        state_next     = S_FIN;
                    end
                end
            end

            S_QLINK:
            begin
                pr_we    = 1'b1;
                pr_waddr = ent_reg.qtail[PID_W-1:0];
                pr_wdata.waits_on    = pvalid_reg[ent_reg.qtail[PID_W-1:0]] ?
                                       pr_rd_reg.waits_on : NO_LOCK;
                pr_wdata.next_waiter = req_ext;
                pvalid_next[ent_reg.qtail[PID_W-1:0]] = 1'b1;
                state_next = S_FIN;
            end

            // Hand the lock to the head waiter
            S_UNL:
            begin
                lk_we           = 1'b1;
                lk_wdata        = ent_reg;
                lk_wdata.holder = ent_reg.qhead;
                lk_wdata.qhead  = nx_head;
                if (nx_head >= NO_PID)
                begin
                    lk_wdata.qtail = NO_PID;
                end
                pr_we    = 1'b1;
                pr_waddr = ent_reg.qhead[PID_W-1:0];
                pr_wdata = '{waits_on: NO_LOCK, next_waiter: pr_rd_reg.next_waiter};
                pvalid_next[ent_reg.qhead[PID_W-1:0]] = 1'b1;
                one_rsp.status    = ST_OK;
                one_rsp.woken_pid = ent_reg.qhead;
                rsp_next   = one_rsp;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_FIN:
            begin
                if (found_reg)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    one_rsp.status = st_reg;
                    rsp_next   = one_rsp;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            // One deadlocked process per word, lowest first
            S_EMIT:
            begin
                one_rsp.status     = st_reg;
                one_rsp.deadlock   = 1'b1;
                one_rsp.member_pid = low_pid;
                one_rsp.last       = ((mask_reg & ~low_bit) == '0);
                rsp_next   = one_rsp;
                done_next  = 1'b1;
                mask_next  = mask_reg & ~low_bit;
                if (one_rsp.last)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            alloc_cnt_reg <= '0;
            pvalid_reg    <= '0;
            done_reg      <= 1'b0;
            found_reg     <= 1'b0;
            cnt_reg       <= '0;
            mask_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            alloc_cnt_reg <= alloc_cnt_next;
            pvalid_reg    <= pvalid_next;
            done_reg      <= done_next;
            found_reg     <= found_next;
            cnt_reg       <= cnt_next;
            mask_reg      <= mask_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        ent_reg     <= ent_next;
        h_reg       <= h_next;
        pursuer_reg <= pursuer_next;
        st_reg      <= st_next;
        rsp_reg     <= rsp_next;
    end

    // Lock table RAM
    always_ff @(posedge clk)
    begin
        if (lk_we)
        begin
            lock_mem[lk_waddr] <= lk_wdata;
        end
        if (lk_re)
        begin
            lk_rd_reg <= lock_mem[lk_raddr];
        end
    end

    // Process table RAM
    always_ff @(posedge clk)
    begin
        if (pr_we)
        begin
            proc_mem[pr_waddr] <= pr_wdata;
        end
        if (pr_re)
        begin
            pr_rd_reg <= proc_mem[pr_raddr];
        end
    end

    `LMDD_ASSERT_IMPL(a_last_frees, done && result.last, !busy, "last word while busy")
    `LMDD_ASSERT_IMPL(a_more_holds, done && !result.last, busy, "non-last word while idle")
    `LMDD_ASSERT_IMPL(a_walk_bound, state_reg == S_WALK_L || state_reg == S_WALK_P,
                      cnt_reg <= (PID_W + 1)'(NUM_PROCS), "chain walk overran")
    `LMDD_ASSERT_IMPL(a_emit_pending, state_reg == S_EMIT, mask_reg != '0,
                      "member list empty while listing")
    `LMDD_ASSERT_NEXT(a_start_busy, start && !busy, busy, "command not taken")

endmodule

// File: sim/tb_lock_manager_deadlock_detect_core.sv
`timescale 1ns / 100ps

module tb_lock_manager_deadlock_detect_core;
    import lmdd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_WORDS   = 460;

    logic clk;
    logic rst_n;
    logic start;
    cmd_t command;
    logic busy;
    logic done;
    rsp_t result;

    lock_manager_deadlock_detect_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Lock table shadow
    logic [PID_W:0]  lk_holder [NUM_LOCKS];
    logic            lk_busy   [NUM_LOCKS];
    logic            lk_alloc  [NUM_LOCKS];
    int              alloc_count;
    logic [LOCK_W:0] pr_waits  [NUM_PROCS];
    logic [PID_W:0]  lk_qhead  [NUM_LOCKS];
    logic [PID_W:0]  lk_qtail  [NUM_LOCKS];
    logic [PID_W:0]  pr_next   [NUM_PROCS];

    rsp_t expected_words [$];
    int   mismatches;
    int   words_seen;
    int   deadlock_words;
    int   idle_cycles;

    function automatic rsp_t mk_word(logic [2:0] st, logic [LOCK_W-1:0] given,
                                     int dl, logic [PID_W-1:0] member,
                                     int woken, int lst);
        rsp_t w;
        w.status     = st;
        w.given_lock = given;
        w.deadlock   = (dl != 0);
        w.member_pid = member;
        w.woken_pid  = (PID_W + 1)'(woken);
        w.last       = (lst != 0);
        return w;
    endfunction

    task automatic reset_lock_table();
        for (int i = 0; i < NUM_LOCKS; i++)
        begin
            lk_holder[i] = NO_PID;
            lk_busy[i]   = 1'b0;
            lk_alloc[i]  = 1'b0;
            lk_qhead[i]  = NO_PID;
            lk_qtail[i]  = NO_PID;
        end
        for (int p = 0; p < NUM_PROCS; p++)
        begin
            pr_waits[p] = NO_LOCK;
            pr_next[p]  = '0;
        end
        alloc_count = 0;
    endtask

    // Applies one command to the shadow table and queues the words it gives
    task automatic predict_lock_op(cmd_t c);
        int          req;
        int          lk;
        int          h;
        int          w;
        int          pursuer;
        int          n;
        bit          found;
        int          members [$];
        logic [2:0]  st;
        int          x;
        int          nx;
        req = c.requester;
        lk  = c.lock_id;
        n   = 0;
        found = 0;
        if (c.op == OP_ALLOC)
        begin
            if (alloc_count >= NUM_LOCKS)
                expected_words.push_back(mk_word(ST_FULL, '0, 0, '0, NO_PID, 1));
            else
            begin
                lk_alloc[alloc_count]  = 1'b1;
                lk_busy[alloc_count]   = 1'b0;
                lk_holder[alloc_count] = NO_PID;
                lk_qhead[alloc_count]  = NO_PID;
                lk_qtail[alloc_count]  = NO_PID;
                expected_words.push_back(mk_word(ST_OK, alloc_count[LOCK_W-1:0], 0, '0,
                                                 NO_PID, 1));
                alloc_count++;
            end
            return;
        end
        if (!lk_alloc[lk])
        begin
            expected_words.push_back(mk_word(ST_NOLOCK, '0, 0, '0, NO_PID, 1));
            return;
        end
        if (c.op == OP_TRY)
        begin
            if (lk_busy[lk])
                expected_words.push_back(mk_word(ST_REFUSED, '0, 0, '0, NO_PID, 1));
            else
            begin
                lk_busy[lk]   = 1'b1;
                lk_holder[lk] = (PID_W + 1)'(req);
                expected_words.push_back(mk_word(ST_OK, '0, 0, '0, NO_PID, 1));
            end
            return;
        end
        if (c.op == OP_LOCK)
        begin
            if (pr_waits[req] < NUM_LOCKS)
            begin
                expected_words.push_back(mk_word(ST_REFUSED, '0, 0, '0, NO_PID, 1));
                return;
            end
            pr_waits[req] = (LOCK_W + 1)'(lk);
            // wait-for chain walk
            pursuer = NO_PID;
            h = lk_holder[lk];
            while (h < NUM_PROCS)
            begin
                if (members.size() >= NUM_PROCS)
                    break;
                if (pursuer == req)
                begin
                    found = 1;
                    break;
                end
                w = pr_waits[h];
                if (w >= NUM_LOCKS)
                    break;
                pursuer = h;
                members.push_back(h);
                h = lk_holder[w];
            end
            if (!found)
                members.delete();
            if (!lk_busy[lk])
            begin
                lk_busy[lk]   = 1'b1;
                lk_holder[lk] = (PID_W + 1)'(req);
                pr_waits[req] = NO_LOCK;
                st = ST_OK;
            end
            else
            begin
                if (lk_qtail[lk] < NUM_PROCS)
                    pr_next[lk_qtail[lk]] = (PID_W + 1)'(req);
                else
                    lk_qhead[lk] = (PID_W + 1)'(req);
                lk_qtail[lk] = (PID_W + 1)'(req);
                pr_next[req] = NO_PID;
                st = ST_QUEUED;
            end
            if (members.size() == 0)
                expected_words.push_back(mk_word(st, '0, 0, '0, NO_PID, 1));
            else
            begin
                members.sort();
                n = members.size();
                if (n > MAX_RES)
                    n = MAX_RES;
                for (int k = 0; k < n; k++)
                    expected_words.push_back(mk_word(st, '0, 1, members[k][PID_W-1:0],
                                                     NO_PID, k + 1 == n));
            end
            return;
        end
        // unlock
        if (lk_holder[lk] != req)
        begin
            expected_words.push_back(mk_word(ST_REFUSED, '0, 0, '0, NO_PID, 1));
            return;
        end
        if (lk_qhead[lk] >= NUM_PROCS)
        begin
            lk_busy[lk]   = 1'b0;
            lk_holder[lk] = NO_PID;
            expected_words.push_back(mk_word(ST_OK, '0, 0, '0, NO_PID, 1));
            return;
        end
        x  = lk_qhead[lk];
        nx = pr_next[x];
        lk_qhead[lk] = (nx < NUM_PROCS) ? (PID_W + 1)'(nx) : NO_PID;
        if (lk_qhead[lk] >= NUM_PROCS)
            lk_qtail[lk] = NO_PID;
        lk_holder[lk] = (PID_W + 1)'(x);
        pr_waits[x]   = NO_LOCK;
        expected_words.push_back(mk_word(ST_OK, '0, 0, '0, x, 1));
    endtask

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            rsp_t exp_w;
            words_seen++;
            if (result.deadlock === 1'b1)
                deadlock_words++;
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word %p", result);
            end
            else
            begin
                exp_w = expected_words.pop_front();
                if (result.status !== exp_w.status || result.given_lock !== exp_w.given_lock
                    || result.deadlock !== exp_w.deadlock
                    || result.member_pid !== exp_w.member_pid
                    || result.woken_pid !== exp_w.woken_pid || result.last !== exp_w.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", exp_w, result);
                end
            end
        end
    end

    // Watchdog: cycles with no command accepted and no word returned
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired");
            $display("status: fail");
            $finish;
        end
    end

    // Directed row: command plus an optional typed expectation
    typedef struct {
        cmd_t       cmd;
        bit         has_exp;
        logic [2:0] exp_status;
        logic [3:0] exp_given;
    } dir_row_t;

    dir_row_t dir_rows [$];

    function automatic cmd_t mk_cmd(logic [1:0] op, int req, int lk);
        cmd_t c;
        c.op        = op;
        c.requester = req[PID_W-1:0];
        c.lock_id   = lk[LOCK_W-1:0];
        return c;
    endfunction

    function automatic dir_row_t row(logic [1:0] op, int req, int lk, int he,
                                     int st, int given);
        dir_row_t r;
        r.cmd        = mk_cmd(op, req, lk);
        r.has_exp    = (he != 0);
        r.exp_status = st[2:0];
        r.exp_given  = given[3:0];
        return r;
    endfunction

    // Sends one word after a random gap; gaps skip during bursts
    task automatic send_word(cmd_t c, bit allow_gap);
        int gap;
        gap = allow_gap ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        command <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_lock_op(c);
    endtask

    task automatic drain_words();
        start <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic cmd_t random_cmd(bit well_formed);
        int op;
        int req;
        int lk;
        req = $urandom_range(0, 15);
        op  = $urandom_range(0, 9);
        // small process and lock sets so chains and cycles form
        if (well_formed)
        begin
            req = $urandom_range(0, 5);
            lk  = $urandom_range(0, alloc_count > 0 ? alloc_count - 1 : 0);
        end
        else
            lk = $urandom_range(0, 15);
        if (op < 1)
            return mk_cmd(OP_ALLOC, req, lk);
        else if (op < 3)
            return mk_cmd(OP_TRY, req, lk);
        else if (op < 6)
            return mk_cmd(OP_LOCK, req, lk);
        return mk_cmd(OP_UNLOCK, req, lk);
    endfunction

    initial
    begin
        bit burst;
        start         = 1'b0;
        command       = '0;
        rst_n         = 1'b0;
        mismatches    = 0;
        words_seen    = 0;
        deadlock_words = 0;
        reset_lock_table();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        dir_rows.push_back(row(OP_TRY,    0, 0,  1, ST_NOLOCK, 0));
        dir_rows.push_back(row(OP_UNLOCK, 15, 15, 1, ST_NOLOCK, 0));
        dir_rows.push_back(row(OP_ALLOC,  15, 15, 1, ST_OK, 0));
        dir_rows.push_back(row(OP_ALLOC,  0, 0,  1, ST_OK, 1));
        dir_rows.push_back(row(OP_ALLOC,  0, 0,  1, ST_OK, 2));
        dir_rows.push_back(row(OP_TRY,    0, 0,  1, ST_OK, 0));
        dir_rows.push_back(row(OP_TRY,    1, 0,  1, ST_REFUSED, 0));
        dir_rows.push_back(row(OP_UNLOCK, 1, 0,  1, ST_REFUSED, 0));
        dir_rows.push_back(row(OP_LOCK,   0, 0,  0, 0, 0));   // self lock
        dir_rows.push_back(row(OP_LOCK,   0, 1,  1, ST_REFUSED, 0));
        dir_rows.push_back(row(OP_LOCK,   15, 1, 0, 0, 0));
        dir_rows.push_back(row(OP_LOCK,   1, 0,  0, 0, 0));   // queue behind 0
        dir_rows.push_back(row(OP_LOCK,   14, 2, 0, 0, 0));
        dir_rows.push_back(row(OP_LOCK,   15, 0, 0, 0, 0));   // 15 waits, 14 held
        dir_rows.push_back(row(OP_UNLOCK, 0, 0,  0, 0, 0));   // wakes 0 itself
        dir_rows.push_back(row(OP_UNLOCK, 0, 0,  0, 0, 0));   // wakes 1
        dir_rows.push_back(row(OP_LOCK,   1, 2,  0, 0, 0));   // 1 -> 14
        dir_rows.push_back(row(OP_LOCK,   14, 0, 0, 0, 0));   // closes a cycle
        dir_rows.push_back(row(OP_UNLOCK, 1, 15, 1, ST_NOLOCK, 0));
        for (int i = 0; i < 13; i++)
            dir_rows.push_back(row(OP_ALLOC, i, 0, 1, ST_OK, 3 + i));
        dir_rows.push_back(row(OP_ALLOC,  7, 9,  1, ST_FULL, 0));

        foreach (dir_rows[i])
        begin
            send_word(dir_rows[i].cmd, 1);
            if (dir_rows[i].has_exp && (expected_words[$].status !== dir_rows[i].exp_status
                || expected_words[$].given_lock !== dir_rows[i].exp_given))
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("table row %0d: predictor gives %p", i, expected_words[$]);
            end
        end
        // Sender holds off until all words have arrived
        drain_words();

        // Random part, with bursts of back-to-back commands
        burst = 0;
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                burst = !burst;
            send_word(random_cmd($urandom_range(0, 9) != 0), !burst);
            if (i == RANDOM_WORDS / 2)
                drain_words();
        end

        drain_words();
        repeat (60) @(posedge clk);
        $display("ran %0d directed and %0d random commands, %0d result words",
                 dir_rows.size(), RANDOM_WORDS, words_seen);
        $display("%0d words reported deadlock members", deadlock_words);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: lock_manager_deadlock_detect_core.f
+incdir+src
src/lmdd_pkg.sv
src/lock_manager_deadlock_detect_core.sv
sim/tb_lock_manager_deadlock_detect_core.sv
